FILE: rtl/swbt_pkg.sv
// Shared types and codes for the sliding-window block tracker.
// Holds the operation codes, the item structs and the port widths.
// No dependencies.
package swbt_pkg;

   localparam int unsigned IdWidth    = 16;
   localparam int unsigned SizeWidth  = 16;
   localparam int unsigned CfgWidth   = 8;
   localparam int unsigned CsrIdxWidth = 8;

   typedef enum logic [1:0] {
      OP_RESTART  = 2'd0,
      OP_ACK      = 2'd1,
      OP_SENT     = 2'd2,
      OP_ROLLBACK = 2'd3
   } op_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_WINDOW_SIZE = 8'd0,
      CSR_RETRY_LIMIT = 8'd1
   } csr_index_type;

   localparam logic [CfgWidth-1:0] WindowSizeReset = 8'd8;
   localparam logic [CfgWidth-1:0] RetryLimitReset = 8'd3;
   localparam logic [IdWidth-1:0]  SendIdReset     = 16'd1;

   typedef struct packed {
      op_type                       operation;
      logic [IdWidth-1:0]           block_id;
      logic signed [SizeWidth-1:0]  block_size;
   } req_item_type;

   typedef struct packed {
      logic               op_ok;
      logic               send_permitted;
      logic               transfer_done;
      logic [IdWidth-1:0] next_send_id;
   } rsp_item_type;

endpackage

FILE: rtl/swbt_in_stage.sv
// Input register of the block tracker: captures one request beat.
// Depends on swbt_pkg for the request struct.
module swbt_in_stage
   import swbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  req_item_type load_item,
   input  logic         drain,
   output logic         valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

FILE: rtl/swbt_window_core.sv
// Window state of the go-back-N sender: ids, final marker, retry count
// and the two config registers. Depends on swbt_pkg.
module swbt_window_core
   import swbt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cfg_write,
   input  csr_index_type          cfg_index,
   input  logic [CfgWidth-1:0]    cfg_data,
   input  logic                   fire,
   input  req_item_type           item,
   output rsp_item_type           result
);

   logic [CfgWidth-1:0] window_size_ff, retry_limit_ff;
   logic [IdWidth-1:0]  send_id_ff, send_id_in;
   logic [IdWidth-1:0]  acked_id_ff, acked_id_in;
   logic [IdWidth-1:0]  final_id_ff, final_id_in;
   logic                final_valid_ff, final_valid_in;
   logic [CfgWidth-1:0] retries_ff, retries_in;
   logic                ok;
   logic [IdWidth-1:0]  ack_expect;
   logic [IdWidth-1:0]  id_span;
   logic                size_positive;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WindowSizeReset;
         retry_limit_ff <= RetryLimitReset;
      end else if (cfg_write) begin
         unique case (cfg_index)
            CSR_WINDOW_SIZE: window_size_ff <= cfg_data;
            CSR_RETRY_LIMIT: retry_limit_ff <= cfg_data;
            default: ;
         endcase
      end
   end

   assign ack_expect    = acked_id_ff + IdWidth'(1);
   assign size_positive = (item.block_size > $signed(SizeWidth'(0)));

   always_comb begin
      send_id_in     = send_id_ff;
      acked_id_in    = acked_id_ff;
      final_id_in    = final_id_ff;
      final_valid_in = final_valid_ff;
      retries_in     = retries_ff;
      ok             = 1'b0;
      unique case (item.operation)
         OP_RESTART: begin
            send_id_in     = SendIdReset;
            acked_id_in    = '0;
            final_id_in    = '0;
            final_valid_in = 1'b0;
            retries_in     = retry_limit_ff;
         end
         OP_ACK: begin
            if (item.block_id == ack_expect) begin
               acked_id_in = ack_expect;
               retries_in  = retry_limit_ff;
               ok          = 1'b1;
            end
         end
         OP_SENT: begin
            if (size_positive) begin
               send_id_in = send_id_ff + IdWidth'(1);
            end else begin
               final_id_in    = send_id_ff;
               final_valid_in = 1'b1;
               ok             = 1'b1;
            end
         end
         OP_ROLLBACK: begin
            if (retries_ff != '0) begin
               retries_in     = retries_ff - CfgWidth'(1);
               final_valid_in = 1'b0;
               final_id_in    = '0;
               send_id_in     = ack_expect;
               ok             = 1'b1;
            end
         end
         default: ;
      endcase
      id_span = send_id_in - acked_id_in;
      result.op_ok          = ok;
      result.send_permitted = (id_span <= {{(IdWidth-CfgWidth){1'b0}}, window_size_ff}) &&
                              !(final_valid_in && (final_id_in == send_id_in));
      result.transfer_done  = final_valid_in && (acked_id_in == final_id_in);
      result.next_send_id   = send_id_in;
   end

   // advance the window only when the beat moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         send_id_ff     <= SendIdReset;
         acked_id_ff    <= '0;
         final_id_ff    <= '0;
         final_valid_ff <= 1'b0;
         retries_ff     <= RetryLimitReset;
      end else if (fire) begin
         send_id_ff     <= send_id_in;
         acked_id_ff    <= acked_id_in;
         final_id_ff    <= final_id_in;
         final_valid_ff <= final_valid_in;
         retries_ff     <= retries_in;
      end
   end

endmodule

FILE: rtl/swbt_rsp_stage.sv
// Result register of the block tracker: holds one response beat until taken.
// Depends on swbt_pkg for the result struct.
module swbt_rsp_stage
   import swbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   input  logic         stall,
   output logic         free,
   output logic         valid,
   output rsp_item_type item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || !stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

FILE: rtl/sliding_window_block_tracker_unit.sv
// Sender-side window tracker for a go-back-N block transfer (top level).
// Built from swbt_in_stage, swbt_window_core and swbt_rsp_stage; uses swbt_pkg.
//
// Each accepted request beat is registered, applied to the window state and
// held in the result register, which drives the response channel. One request
// can be taken every cycle while the response channel is not stalled; the
// result register and the window update set that rate. Config writes are
// always ready and should be made only while no request is in flight; a new
// retry limit is loaded at the next restart or accepted acknowledgement.
module sliding_window_block_tracker_unit
   import swbt_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [IdWidth-1:0]          req_block_id,
   input  logic signed [SizeWidth-1:0] req_block_size,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_op_ok,
   output logic                        rsp_send_permitted,
   output logic                        rsp_transfer_done,
   output logic [IdWidth-1:0]          rsp_next_send_id,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CsrIdxWidth-1:0]      csr_index,
   input  logic [CfgWidth-1:0]         csr_data
);

   req_item_type req_item, s1_item;
   rsp_item_type core_result, rsp_item;
   logic         s1_valid, rsp_free, s1_fire, req_load;

   assign req_item.operation  = op_type'(req_operation);
   assign req_item.block_id   = req_block_id;
   assign req_item.block_size = req_block_size;

   assign s1_fire   = s1_valid && rsp_free;
   assign req_stall = s1_valid && !rsp_free;
   assign req_load  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   swbt_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (req_load),
      .load_item (req_item),
      .drain     (s1_fire),
      .valid     (s1_valid),
      .item      (s1_item)
   );

   swbt_window_core u_window_core (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (csr_valid && csr_ready),
      .cfg_index (csr_index_type'(csr_index)),
      .cfg_data  (csr_data),
      .fire      (s1_fire),
      .item      (s1_item),
      .result    (core_result)
   );

   swbt_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_fire),
      .load_item (core_result),
      .stall     (rsp_stall),
      .free      (rsp_free),
      .valid     (rsp_valid),
      .item      (rsp_item)
   );

   assign rsp_op_ok          = rsp_item.op_ok;
   assign rsp_send_permitted = rsp_item.send_permitted;
   assign rsp_transfer_done  = rsp_item.transfer_done;
   assign rsp_next_send_id   = rsp_item.next_send_id;

endmodule

FILE: rtl/swbt_checker.sv
// Port-level checks for the block tracker top level, bound to every instance.
// Depends on swbt_pkg and sliding_window_block_tracker_unit.
module swbt_checker
   import swbt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [IdWidth-1:0] rsp_next_send_id
);

   // no response beat right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // an accepted beat reaches the output through the input and result registers when not held off
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted request beat did not reach the response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_next_send_id))
      else $error("response payload changed while stalled");

endmodule

bind sliding_window_block_tracker_unit swbt_checker u_swbt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_next_send_id (rsp_next_send_id)
);
